FILE: hdl/rc4fdc_pkg.sv
package rc4fdc_pkg;

	localparam int KEY_W   = 48;
	localparam int IV_W    = 48;
	localparam int BYTE_W  = 8;
	localparam int CRC_W   = 32;
	localparam int CRC_BYTES = 12;

	localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_DATA  = 1'b1;

	typedef logic [3:0] op_t;

	localparam op_t OP_NONE  = 4'd0;
	localparam op_t OP_CRC   = 4'd1;
	localparam op_t OP_INIT  = 4'd2;
	localparam op_t OP_K_RDN = 4'd3;
	localparam op_t OP_K_RDJ = 4'd4;
	localparam op_t OP_K_WRN = 4'd5;
	localparam op_t OP_K_WRJ = 4'd6;
	localparam op_t OP_D_RDI = 4'd7;
	localparam op_t OP_D_RDJ = 4'd8;
	localparam op_t OP_D_SWP = 4'd9;
	localparam op_t OP_D_OUT = 4'd10;

	typedef struct packed {
		logic start_ld;
		logic data_ld;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic crc_last;
		logic cnt_last;
		logic out_busy;
	} sts_t;

endpackage

FILE: hdl/rc4fdc_ctrl.sv
module rc4fdc_ctrl import rc4fdc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic s_tuser,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CRC   = 4'd1;
	localparam logic [3:0] ST_INIT  = 4'd2;
	localparam logic [3:0] ST_K_RDN = 4'd3;
	localparam logic [3:0] ST_K_RDJ = 4'd4;
	localparam logic [3:0] ST_K_WRN = 4'd5;
	localparam logic [3:0] ST_K_WRJ = 4'd6;
	localparam logic [3:0] ST_D_RDI = 4'd7;
	localparam logic [3:0] ST_D_RDJ = 4'd8;
	localparam logic [3:0] ST_D_SWP = 4'd9;
	localparam logic [3:0] ST_D_OUT = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_nx;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;

	always_comb begin
		state_nx     = state_q;
		cmd.start_ld = accept & (s_tuser == CMD_START);
		cmd.data_ld  = accept & (s_tuser == CMD_DATA);
		cmd.op       = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nx = (s_tuser == CMD_DATA) ? ST_D_RDI : ST_CRC;
				end
			end
			ST_CRC: begin
				cmd.op = OP_CRC;
				if (sts.crc_last) begin
					state_nx = ST_INIT;
				end
			end
			ST_INIT: begin
				cmd.op = OP_INIT;
				if (sts.cnt_last) begin
					state_nx = ST_K_RDN;
				end
			end
			ST_K_RDN: begin
				cmd.op   = OP_K_RDN;
				state_nx = ST_K_RDJ;
			end
			ST_K_RDJ: begin
				cmd.op   = OP_K_RDJ;
				state_nx = ST_K_WRN;
			end
			ST_K_WRN: begin
				cmd.op   = OP_K_WRN;
				state_nx = ST_K_WRJ;
			end
			ST_K_WRJ: begin
				cmd.op   = OP_K_WRJ;
				state_nx = sts.cnt_last ? ST_IDLE : ST_K_RDN;
			end
			ST_D_RDI: begin
				cmd.op   = OP_D_RDI;
				state_nx = ST_D_RDJ;
			end
			ST_D_RDJ: begin
				cmd.op   = OP_D_RDJ;
				state_nx = ST_D_SWP;
			end
			ST_D_SWP: begin
				cmd.op   = OP_D_SWP;
				state_nx = ST_D_OUT;
			end
			ST_D_OUT: begin
				cmd.op = OP_D_OUT;
				if (!sts.out_busy) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

FILE: hdl/rc4fdc_dp.sv
module rc4fdc_dp import rc4fdc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [KEY_W-1:0]  cfg_wr_data,
	input  logic [IV_W-1:0]   frame_iv,
	input  logic [BYTE_W-1:0] data_in,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              m_tready,
	output logic              m_tvalid,
	output logic [BYTE_W-1:0] m_tdata
);

	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
			input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc_in ^ {b, {(CRC_W-BYTE_W){1'b0}}};
		for (int k = 0; k < BYTE_W; k++) begin
			c = c[CRC_W-1] ? ({c[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {c[CRC_W-2:0], 1'b0};
		end
		return c;
	endfunction

	// 16-byte key: key/iv interleaved, then crc little-endian
	function automatic logic [BYTE_W-1:0] key_byte(input logic [KEY_W-1:0] k,
			input logic [IV_W-1:0] iv, input logic [CRC_W-1:0] crc, input logic [3:0] idx);
		logic [BYTE_W-1:0] r;
		if (idx[3:2] == 2'b11) begin
			r = crc[8*idx[1:0] +: BYTE_W];
		end else if (idx[0]) begin
			r = iv[8*idx[3:1] +: BYTE_W];
		end else begin
			r = k[8*idx[3:1] +: BYTE_W];
		end
		return r;
	endfunction

	logic [BYTE_W-1:0] mem [256];

	logic [KEY_W-1:0]  key_q;
	logic [IV_W-1:0]   iv_q;
	logic [BYTE_W-1:0] din_q;
	logic [CRC_W-1:0]  crc_q;
	logic [7:0]        cnt_q;
	logic [7:0]        i_q;
	logic [7:0]        j_q;
	logic [7:0]        si_q;
	logic [7:0]        sj_q;
	logic [7:0]        t_q;
	logic [7:0]        rdata_q;
	logic [BYTE_W-1:0] dout_q;
	logic              mvalid_q;

	logic [7:0] raddr;
	logic [7:0] waddr;
	logic [7:0] wdata;
	logic       mem_we;
	logic [7:0] kb;
	logic [7:0] acc_sum;
	logic [7:0] j_sum;
	logic [7:0] i_nx;
	logic [7:0] t_nx;
	logic [7:0] ks;
	logic       out_load;

	assign kb      = key_byte(key_q, iv_q, crc_q, cnt_q[3:0]);
	assign acc_sum = j_q + rdata_q + kb;
	assign j_sum   = j_q + rdata_q;
	assign i_nx    = i_q + 8'd1;
	assign t_nx    = si_q + rdata_q;

	// S[i] was written in the same edge as the S[t] read; patch both swapped entries
	assign ks = (t_q == j_q) ? si_q : ((t_q == i_q) ? sj_q : rdata_q);

	assign sts.crc_last = (cnt_q == 8'(CRC_BYTES - 1));
	assign sts.cnt_last = (cnt_q == 8'hff);
	assign sts.out_busy = mvalid_q & ~m_tready;

	assign out_load = (cmd.op == OP_D_OUT) & ~sts.out_busy;

	always_comb begin
		raddr  = cnt_q;
		waddr  = cnt_q;
		wdata  = rdata_q;
		mem_we = 1'b0;
		unique case (cmd.op)
			OP_INIT: begin
				mem_we = 1'b1;
				wdata  = cnt_q;
			end
			OP_K_RDJ: begin
				raddr = acc_sum;
			end
			OP_K_WRN: begin
				mem_we = 1'b1;
			end
			OP_K_WRJ: begin
				mem_we = 1'b1;
				waddr  = j_q;
				wdata  = si_q;
			end
			OP_D_RDI: begin
				raddr = i_nx;
			end
			OP_D_RDJ: begin
				raddr = j_sum;
			end
			OP_D_SWP: begin
				mem_we = 1'b1;
				waddr  = i_q;
				raddr  = t_nx;
			end
			OP_D_OUT: begin
				mem_we = 1'b1;
				waddr  = j_q;
				wdata  = si_q;
				// keep S[t] in rdata_q while the output is stalled
				raddr  = t_q;
			end
			default: begin
				raddr = cnt_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q    <= '0;
			cnt_q    <= '0;
			i_q      <= '0;
			j_q      <= '0;
			mvalid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				key_q <= cfg_wr_data;
			end
			if (cmd.start_ld) begin
				cnt_q <= '0;
			end
			case (cmd.op)
				OP_CRC: begin
					cnt_q <= sts.crc_last ? 8'd0 : cnt_q + 8'd1;
				end
				OP_INIT: begin
					cnt_q <= cnt_q + 8'd1;
					j_q   <= '0;
				end
				OP_K_RDJ: begin
					j_q <= acc_sum;
				end
				OP_K_WRJ: begin
					cnt_q <= cnt_q + 8'd1;
					if (sts.cnt_last) begin
						i_q <= '0;
						j_q <= '0;
					end
				end
				OP_D_RDI: begin
					i_q <= i_nx;
				end
				OP_D_RDJ: begin
					j_q <= j_sum;
				end
				default: begin
				end
			endcase
			if (out_load) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_ld) begin
			iv_q  <= frame_iv;
			crc_q <= '0;
		end
		if (cmd.data_ld) begin
			din_q <= data_in;
		end
		if (cmd.op == OP_CRC) begin
			crc_q <= crc_byte(crc_q, kb);
		end
		if (cmd.op == OP_K_RDJ || cmd.op == OP_D_RDJ) begin
			si_q <= rdata_q;
		end
		if (cmd.op == OP_D_SWP) begin
			sj_q <= rdata_q;
			t_q  <= t_nx;
		end
		if (out_load) begin
			dout_q <= din_q ^ ks;
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = dout_q;

endmodule

FILE: hdl/rc4_frame_decrypt_crc_key_core.sv
// channel   dir  tdata (low bit first)              tuser
// s_*       in   frame_iv[47:0], data_in[55:48]     command (0 start, 1 data)
// m_*       out  data_out[7:0]                      -
// cfg_*     in   secret_key[47:0], written when cfg_wr_en is high
//
// A data request holds off new input until done: accept, read S[i], read S[j],
// swap with keystream read, output. The state memory has one read and one
// write port, which is why each of these steps is a separate state.
// A start request: CRC over key bytes 0 to 11 (one byte a cycle), fill of the
// 256-entry table, key schedule (read S[i], S[j], write S[i], S[j] per step).
// Reset clears control and the key register; the state memory holds garbage
// until the first start. A result waiting on m_tready holds the last step.
module rc4_frame_decrypt_crc_key_core import rc4fdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [47:0] cfg_wr_data,  // secret_key
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,      // frame_iv[47:0], data_in[55:48]
	input  logic        s_tuser,      // command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata       // data_out[7:0]
);

	cmd_t cmd;
	sts_t sts;

	rc4fdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rc4fdc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.frame_iv    (s_tdata[47:0]),
		.data_in     (s_tdata[55:48]),
		.cmd         (cmd),
		.sts         (sts),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.m_tdata     (m_tdata)
	);

endmodule
